/* rtl/crc16pe_pkg.sv */
// Package for the CRC-16 preset engine: preset table, bit reversal and start values.
`timescale 1ns / 1ps
`default_nettype none

package crc16pe_pkg;

	localparam logic [15:0] CRC_POLY_CCITT = 16'h1021;
	localparam logic [15:0] CRC_POLY_IBM   = 16'h8005;
	localparam logic [15:0] CRC_ALL_ONES   = 16'hFFFF;
	localparam logic [15:0] CRC_ALL_ZEROS  = 16'h0000;
	localparam logic [15:0] CRC_TOP_BIT    = 16'h8000;

	// Preset codes held in the configuration register
	localparam logic [2:0] PRESET_X25         = 3'd0;
	localparam logic [2:0] PRESET_CCITT       = 3'd1;
	localparam logic [2:0] PRESET_CCITT_FALSE = 3'd2;
	localparam logic [2:0] PRESET_MODBUS      = 3'd3;
	localparam logic [2:0] PRESET_USB         = 3'd4;
	localparam logic [2:0] PRESET_XMODEM      = 3'd5;
	localparam logic [2:0] PRESET_IBM         = 3'd6;
	localparam logic [2:0] PRESET_MAXIM       = 3'd7;

	typedef logic [2:0] preset_code_t;

	typedef struct packed {
		logic [15:0] poly;
		logic [15:0] init;
		logic        refin;
		logic        refout;
		logic [15:0] xorout;
	} preset_t;

	// Look up the parameter set of one preset code
	function automatic preset_t preset_lookup(input preset_code_t code);
		preset_t p;
		unique case (code)
			PRESET_X25:         p = '{CRC_POLY_CCITT, CRC_ALL_ONES,  1'b1, 1'b1, CRC_ALL_ONES};
			PRESET_CCITT:       p = '{CRC_POLY_CCITT, CRC_ALL_ZEROS, 1'b1, 1'b1, CRC_ALL_ZEROS};
			PRESET_CCITT_FALSE: p = '{CRC_POLY_CCITT, CRC_ALL_ONES,  1'b0, 1'b0, CRC_ALL_ZEROS};
			PRESET_MODBUS:      p = '{CRC_POLY_IBM,   CRC_ALL_ONES,  1'b1, 1'b1, CRC_ALL_ZEROS};
			PRESET_USB:         p = '{CRC_POLY_IBM,   CRC_ALL_ONES,  1'b1, 1'b1, CRC_ALL_ONES};
			PRESET_XMODEM:      p = '{CRC_POLY_CCITT, CRC_ALL_ZEROS, 1'b0, 1'b0, CRC_ALL_ZEROS};
			PRESET_IBM:         p = '{CRC_POLY_IBM,   CRC_ALL_ZEROS, 1'b1, 1'b1, CRC_ALL_ZEROS};
			PRESET_MAXIM:       p = '{CRC_POLY_IBM,   CRC_ALL_ZEROS, 1'b1, 1'b1, CRC_ALL_ONES};
			default:            p = '{CRC_POLY_CCITT, CRC_ALL_ONES,  1'b1, 1'b1, CRC_ALL_ONES};
		endcase
		return p;
	endfunction

	// Reverse the bit order of a 16-bit word
	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = v[15 - i];
		end
		return r;
	endfunction

	// Register contents at the start of a message
	function automatic logic [15:0] start_value(input preset_code_t code);
		preset_t p;
		p = preset_lookup(code);
		return p.refin ? rev16(p.init) : p.init;
	endfunction

endpackage

`default_nettype wire

/* rtl/crc16pe_core.sv */
// Byte fold and message finish logic of the CRC-16 preset engine.
`timescale 1ns / 1ps
`default_nettype none

module crc16pe_core
	import crc16pe_pkg::*;
(
	input  wire preset_t     preset,
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	output logic      [15:0] crc_next,
	output logic      [15:0] crc_result
);

	logic [15:0] rpoly;
	logic [15:0] acc;
	logic [15:0] folded;
	logic [15:0] ordered;

	// Fold one byte in eight bit steps, right-shifting for reflected presets; pass crc_in through when byte_valid is low
	always_comb begin
		rpoly = rev16(preset.poly);
		if (preset.refin) begin
			acc = crc_in ^ {8'h00, data_byte};
			for (int i = 0; i < 8; i++) begin
				acc = acc[0] ? ((acc >> 1) ^ rpoly) : (acc >> 1);
			end
		end else begin
			acc = crc_in ^ {data_byte, 8'h00};
			for (int i = 0; i < 8; i++) begin
				acc = ((acc & CRC_TOP_BIT) != CRC_ALL_ZEROS) ? ((acc << 1) ^ preset.poly)
				                                             : (acc << 1);
			end
		end
		folded = byte_valid ? acc : crc_in;
	end

	// Finish: reflect when the output order differs, then apply the final XOR
	always_comb begin
		ordered    = (preset.refout != preset.refin) ? rev16(folded) : folded;
		crc_next   = folded;
		crc_result = ordered ^ preset.xorout;
	end

endmodule

`default_nettype wire

/* rtl/crc16_preset_engine.sv */
// Top level of the CRC-16 preset engine: input stage, running CRC and result register.
`timescale 1ns / 1ps
`default_nettype none

// CRC-16 over a byte stream with eight selectable standard presets (X25, CCITT,
// CCITT-FALSE, MODBUS, USB, XMODEM, IBM, MAXIM). Each input request carries one
// byte in s_axis_tdata, a byte-present flag in s_axis_tuser and an end-of-message
// mark in s_axis_tlast; a request with tuser low and tlast high closes the message
// without a byte. Every request marked last yields one result request with the
// finished CRC, after which the running CRC restarts from the preset's initial
// value. Throughput is one byte per clock: the whole eight-bit fold sits between
// the input stage register and the running CRC register, and a finished CRC is
// written from the input stage into the result register. The result register lets
// the input keep flowing while a finished CRC waits; only a second last-marked
// request stalls until that result is taken. Write cfg_wr_data with cfg_wr_en
// only while no request is in flight; the write also restarts the running CRC.
module crc16_preset_engine
	import crc16pe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_wr_data,   // crc_preset
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  wire logic        s_axis_tlast,  // last_byte
	input  wire logic        s_axis_tuser,  // [0] byte_valid
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [15:0] m_axis_tdata   // [15:0] crc_value
);

	preset_code_t preset_q;
	logic [15:0]  crc_q;

	logic         in_valid_s1;
	logic [7:0]   in_byte_s1;
	logic         in_bvalid_s1;
	logic         in_last_s1;

	logic         out_valid_s2;
	logic [15:0]  out_crc_s2;

	preset_t      preset;
	logic [15:0]  crc_next;
	logic [15:0]  crc_result;
	logic         out_free;
	logic         s1_adv;

	// Handshake: the stage advances unless it holds a last request while the result slot is full and not taken
	always_comb begin
		preset        = preset_lookup(preset_q);
		out_free      = !out_valid_s2 || m_axis_tready;
		s1_adv        = in_valid_s1 && (!in_last_s1 || out_free);
		s_axis_tready = !in_valid_s1 || s1_adv;
		m_axis_tvalid = out_valid_s2;
		m_axis_tdata  = out_crc_s2;
	end

	crc16pe_core u_core (
		.preset     (preset),
		.crc_in     (crc_q),
		.data_byte  (in_byte_s1),
		.byte_valid (in_bvalid_s1),
		.crc_next   (crc_next),
		.crc_result (crc_result)
	);

	// Input stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_byte_s1   <= s_axis_tdata;
			in_bvalid_s1 <= s_axis_tuser;
			in_last_s1   <= s_axis_tlast;
		end
	end

	// Preset and running CRC: restart on a preset write or at the end of a message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= PRESET_X25;
			crc_q    <= start_value(PRESET_X25);
		end else if (cfg_wr_en) begin
			preset_q <= cfg_wr_data;
			crc_q    <= start_value(cfg_wr_data);
		end else if (s1_adv) begin
			crc_q <= in_last_s1 ? start_value(preset_q) : crc_next;
		end
	end

	// Result valid: set by a finished message, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_adv && in_last_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (s1_adv && in_last_s1) begin
			out_crc_s2 <= crc_result;
		end
	end

`ifndef SYNTHESIS
	// A preset write restarts the running CRC from the new start value
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> crc_q == start_value(preset_q))
		else $error("running CRC not restarted after preset write");

	// Closing a message restarts the running CRC
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && in_last_s1 && !cfg_wr_en) |=> crc_q == start_value(preset_q))
		else $error("running CRC not restarted after end of message");

	// A stalled input stage keeps its request
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !s1_adv) |=> in_valid_s1 && $stable(in_byte_s1)
			&& $stable(in_bvalid_s1) && $stable(in_last_s1))
		else $error("stalled input stage lost its request");

	// A pending result is never overwritten by a new finished message
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !m_axis_tready) |=> out_valid_s2 && $stable(out_crc_s2))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
